// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by sorted_merge_annotator_top: clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// Types, sizes and action codes of the sorted merge annotator
// ----------------------------------------------------------------------------
package sma_pkg;

  // table size and derived widths
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int ID_W     = 31;
  localparam int LEVEL_W  = 31;
  localparam int CODE_W   = 16;
  localparam int VALUE_W  = 64;
  localparam int EIDX_W   = 6;

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_PROBE  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     row_id;
    logic [LEVEL_W-1:0]  level_key;
    logic [CODE_W-1:0]   var_code;
    logic [VALUE_W-1:0]  value_word;
  } in_item_t;

  typedef struct packed {
    logic              entry_valid;
    logic [EIDX_W-1:0] entry_index;
    logic              to_insert;
    logic              to_update;
    logic [ID_W-1:0]   matched_id;
    logic              more_pending;
    logic              any_insert;
    logic              any_update;
    logic              last;
  } out_item_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

// ===== sv/sma_in_if.sv =====
// ----------------------------------------------------------------------------
// sma_in_if
// Valid/ready channel carrying one input item per transaction
// ----------------------------------------------------------------------------
interface sma_in_if
  import sma_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sma_out_if.sv =====
// ----------------------------------------------------------------------------
// sma_out_if
// Valid/ready channel carrying one result item per transaction
// ----------------------------------------------------------------------------
interface sma_out_if
  import sma_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sorted_merge_annotator_top.sv =====
// ----------------------------------------------------------------------------
// sorted_merge_annotator_top
// Sorted merge of probe rows against a loaded entry table
// ----------------------------------------------------------------------------
// One input item is handled at a time; items is ready only while the block is
// idle. A load or clear takes the item in the idle state and then loads its
// empty result into the result register. A probe first walks the table from
// the cursor with one shared key comparator over the single read port of the
// table memory, reading and then comparing each entry looked at (ST_READ,
// then ST_CMP), and then gives one result per resolved entry at one result a
// cycle while the result register can load. A finish skips the walk and gives
// its results at one a cycle under the same condition. The result register
// lets a new item be taken while the last result still waits on results.ready.
module sorted_merge_annotator_top
  import sma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sma_in_if.sink    items,
  sma_out_if.source results
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CMP, ST_EMIT} state_t;

  state_t             state;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   cursor;
  logic               insert_seen;
  logic               update_seen;
  logic [CNT_W-1:0]   scan;
  logic [CNT_W-1:0]   emit_idx;
  logic [CNT_W-1:0]   end_idx;
  logic               has_match;
  logic               match_upd;
  logic [ID_W-1:0]    row_id_q;
  logic [LEVEL_W-1:0] level_q;
  logic [CODE_W-1:0]  code_q;
  logic [VALUE_W-1:0] value_q;
  logic               out_valid;
  out_item_t          out_data;

  logic               in_fire;
  logic               tbl_wr;
  entry_t             tbl_wdata;
  logic               tbl_rd;
  entry_t             tbl_rdata;
  logic               table_full;
  logic               scan_done;
  logic               row_lt;
  logic               row_gt;
  logic               can_load;
  logic               emit_empty;
  logic               emit_last;
  logic               emit_match;
  out_item_t          emit_item;
  logic               both_flags;

  // handshakes
  assign items.ready   = (state == ST_IDLE);
  assign in_fire       = items.valid && items.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;
  assign can_load      = !out_valid || results.ready;

  // table write on load, read during the walk
  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));
  assign tbl_wr     = in_fire && (items.data.action == ACT_LOAD) && !table_full;
  assign tbl_wdata  = '{level: items.data.level_key, code: items.data.var_code,
                        value: items.data.value_word};
  assign scan_done  = (scan >= entry_count);
  assign tbl_rd     = (state == ST_READ) && !scan_done;

  sma_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_rd),
    .rd_addr (scan[IDX_W-1:0]),
    .rd_data (tbl_rdata)
  );

  // shared key comparator: row against the entry just read
  assign row_lt = {level_q, code_q} < {tbl_rdata.level, tbl_rdata.code};
  assign row_gt = {level_q, code_q} > {tbl_rdata.level, tbl_rdata.code};

  // next result of the current item
  assign emit_empty = (emit_idx == end_idx);
  assign emit_last  = ((emit_idx + CNT_W'(1)) == end_idx);
  assign emit_match = has_match && emit_last;

  always_comb begin
    emit_item              = '0;
    emit_item.more_pending = (cursor < entry_count);
    emit_item.any_insert   = insert_seen;
    emit_item.any_update   = update_seen;
    if (emit_empty) begin
      emit_item.last = 1'b1;
    end else begin
      emit_item.entry_valid = 1'b1;
      emit_item.entry_index = EIDX_W'(emit_idx);
      emit_item.to_insert   = !emit_match;
      emit_item.to_update   = emit_match && match_upd;
      emit_item.matched_id  = emit_match ? row_id_q : '0;
      emit_item.last        = emit_last;
    end
  end

  // sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      cursor      <= '0;
      insert_seen <= 1'b0;
      update_seen <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // result register empties when taken and nothing new is loaded
      if (results.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            row_id_q  <= items.data.row_id;
            level_q   <= items.data.level_key;
            code_q    <= items.data.var_code;
            value_q   <= items.data.value_word;
            has_match <= 1'b0;
            match_upd <= 1'b0;
            scan      <= cursor;
            case (items.data.action)
              ACT_LOAD: begin
                emit_idx <= cursor;
                end_idx  <= cursor;
                if (!table_full) begin
                  entry_count <= entry_count + CNT_W'(1);
                end
                state <= ST_EMIT;
              end
              ACT_PROBE: begin
                emit_idx <= cursor;
                end_idx  <= cursor;
                state    <= ST_READ;
              end
              ACT_FINISH: begin
                emit_idx <= cursor;
                end_idx  <= entry_count;
                cursor   <= entry_count;
                if (cursor < entry_count) begin
                  insert_seen <= 1'b1;
                end
                state <= ST_EMIT;
              end
              default: begin
                entry_count <= '0;
                cursor      <= '0;
                insert_seen <= 1'b0;
                update_seen <= 1'b0;
                emit_idx    <= '0;
                end_idx     <= '0;
                state       <= ST_EMIT;
              end
            endcase
          end
        end
        ST_READ: begin
          // table exhausted: the walk ends here
          if (scan_done) begin
            end_idx <= scan;
            cursor  <= scan;
            if (scan != emit_idx) begin
              insert_seen <= 1'b1;
            end
            state <= ST_EMIT;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (row_gt) begin
            scan  <= scan + CNT_W'(1);
            state <= ST_READ;
          end else begin
            if (scan != emit_idx) begin
              insert_seen <= 1'b1;
            end
            if (row_lt) begin
              end_idx <= scan;
              cursor  <= scan;
            end else begin
              has_match <= 1'b1;
              match_upd <= (value_q != tbl_rdata.value);
              if (value_q != tbl_rdata.value) begin
                update_seen <= 1'b1;
              end
              end_idx <= scan + CNT_W'(1);
              cursor  <= scan + CNT_W'(1);
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_data  <= emit_item;
            emit_idx  <= emit_idx + CNT_W'(1);
            if (emit_item.last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // both resolution flags on one result
  assign both_flags = results.data.to_insert && results.data.to_update;

  // checks on the walk and the results
  `ASSERT_ALWAYS(a_cursor_in_table, cursor <= entry_count, "cursor beyond loaded entries")
  `ASSERT_ALWAYS(a_count_in_range, entry_count <= CNT_W'(TABLE_DEPTH), "entry count overflow")
  `ASSERT_ALWAYS(a_cmp_in_table, (state != ST_CMP) || (scan < entry_count), "compare past end")
  `ASSERT_ALWAYS(a_insert_xor_update, !(results.valid && both_flags), "insert and update")
  `ASSERT_NEXT(a_out_hold, results.valid && !results.ready, results.valid && $stable(results.data), "result dropped or changed while waiting")

endmodule

// ===== sv/sma_table.sv =====
// ----------------------------------------------------------------------------
// sma_table
// Entry table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sma_table
  import sma_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted merge annotator: a short directed part
// covers the key extremes and the corner cases of the walk (empty table,
// skipped rows, out-of-order and late loads, repeated finish). After it come a
// full-table run and sorted load/probe/finish runs with random content and noise.
// A scoreboard class predicts every result transaction and compares it field
// by field. Random stalls and gaps fall on both channels, and there is one long
// result hold-off while inputs keep coming.
// ----------------------------------------------------------------------------
module tb_top
  import sma_pkg::*;
;

  localparam int          RANDOM_ITEMS = 12;
  localparam int          FULL_PROBES  = 8;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          KEY_W        = LEVEL_W + CODE_W;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
  localparam logic [CODE_W-1:0]  CODE_MAX  = {CODE_W{1'b1}};
  localparam logic [ID_W-1:0]    ID_MAX    = {ID_W{1'b1}};
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the entry table, cursor and sticky flags
  // --------------------------------------------------------------------------
  class merge_scoreboard;
    logic [LEVEL_W-1:0] tbl_level[TABLE_DEPTH];
    logic [CODE_W-1:0]  tbl_code[TABLE_DEPTH];
    logic [VALUE_W-1:0] tbl_value[TABLE_DEPTH];
    int unsigned        n_entries;
    int unsigned        walk_pos;
    logic               ins_flag;
    logic               upd_flag;
    out_item_t          annotation_q[$];
    int unsigned        mismatch_count;

    function new();
      n_entries      = 0;
      walk_pos       = 0;
      ins_flag       = 1'b0;
      upd_flag       = 1'b0;
      mismatch_count = 0;
    endfunction

    // work out the result transactions caused by one accepted input
    function void note_item(in_item_t it);
      out_item_t batch[$];
      out_item_t r;
      case (it.action)
        ACT_LOAD: begin
          // a load into a full table is dropped
          if (n_entries < TABLE_DEPTH) begin
            tbl_level[n_entries] = it.level_key;
            tbl_code[n_entries]  = it.var_code;
            tbl_value[n_entries] = it.value_word;
            n_entries++;
          end
        end
        ACT_PROBE: begin
          // entries sorting before the row need insert; an equal key matches
          while (walk_pos < n_entries) begin
            if (it.level_key < tbl_level[walk_pos] ||
                (it.level_key == tbl_level[walk_pos] && it.var_code < tbl_code[walk_pos]))
              break;
            r             = '0;
            r.entry_valid = 1'b1;
            r.entry_index = EIDX_W'(walk_pos);
            if (it.level_key > tbl_level[walk_pos] || it.var_code > tbl_code[walk_pos]) begin
              r.to_insert = 1'b1;
              ins_flag    = 1'b1;
              batch.push_back(r);
              walk_pos++;
            end else begin
              r.to_update = (it.value_word != tbl_value[walk_pos]);
              if (r.to_update)
                upd_flag = 1'b1;
              r.matched_id = it.row_id;
              batch.push_back(r);
              walk_pos++;
              break;
            end
          end
        end
        ACT_FINISH: begin
          // everything still pending needs insert
          while (walk_pos < n_entries) begin
            r             = '0;
            r.entry_valid = 1'b1;
            r.entry_index = EIDX_W'(walk_pos);
            r.to_insert   = 1'b1;
            ins_flag      = 1'b1;
            batch.push_back(r);
            walk_pos++;
          end
        end
        default: begin
          n_entries = 0;
          walk_pos  = 0;
          ins_flag  = 1'b0;
          upd_flag  = 1'b0;
        end
      endcase
      // nothing resolved still gives one empty result
      if (batch.size() == 0)
        batch.push_back('0);
      foreach (batch[k]) begin
        batch[k].more_pending = (walk_pos < n_entries);
        batch[k].any_insert   = ins_flag;
        batch[k].any_update   = upd_flag;
        batch[k].last         = (k == batch.size() - 1);
        annotation_q.push_back(batch[k]);
      end
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatch_count++;
      end
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (annotation_q.size() == 0) begin
        $error("result transaction with no prediction waiting");
        mismatch_count++;
        return;
      end
      want = annotation_q.pop_front();
      cmp("entry_valid",  64'(want.entry_valid),  64'(got.entry_valid));
      cmp("entry_index",  64'(want.entry_index),  64'(got.entry_index));
      cmp("to_insert",    64'(want.to_insert),    64'(got.to_insert));
      cmp("to_update",    64'(want.to_update),    64'(got.to_update));
      cmp("matched_id",   64'(want.matched_id),   64'(got.matched_id));
      cmp("more_pending", 64'(want.more_pending), 64'(got.more_pending));
      cmp("any_insert",   64'(want.any_insert),   64'(got.any_insert));
      cmp("any_update",   64'(want.any_update),   64'(got.any_update));
      cmp("last",         64'(want.last),         64'(got.last));
    endfunction

    function int unsigned pending();
      return annotation_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  sma_in_if  items_if ();
  sma_out_if results_if ();

  sorted_merge_annotator_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  merge_scoreboard sb = new();
  bit              hold_req = 1'b0;
  bit              no_idle  = 1'b0;
  int unsigned     n_sent   = 0;

  initial begin
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result(results_if.data);
  end

  // result sink with random stalls and one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned run;
    results_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        results_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        results_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = ($urandom_range(0, 99) < 60) ? 0 :
                ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(15, 60);
        run   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(20, 50);
        if (stall != 0) begin
          results_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        results_if.ready <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom);
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    return LEVEL_W'($urandom);
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    return CODE_W'($urandom);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // random gap after an accepted transaction, mostly short
  task automatic idle_gap();
    int unsigned r;
    int unsigned gap;
    if (no_idle)
      return;
    r   = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap != 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(action_t act, logic [ID_W-1:0] id, logic [LEVEL_W-1:0] level,
                           logic [CODE_W-1:0] code, logic [VALUE_W-1:0] value);
    in_item_t it;
    it.action     = act;
    it.row_id     = id;
    it.level_key  = level;
    it.var_code   = code;
    it.value_word = value;
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    do @(posedge clk); while (!items_if.ready);
    sb.note_item(it);
    n_sent++;
    idle_gap();
  endtask

  // sender stops until every predicted result has come back
  task automatic drain_results();
    items_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // clear, load a sorted table, probe its first entries with sorted rows, usually finish
  task automatic run_sequence(int unsigned n_load, int unsigned extra_loads,
                              int unsigned n_probe);
    logic [KEY_W-1:0]   keys[$];
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] vals[TABLE_DEPTH];
    int unsigned        pick;
    send_item(ACT_CLEAR, rand_id(), rand_level(), rand_code(), rand_value());
    for (int i = 0; i < n_load; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        k = keys[i-1];
        k = {k[KEY_W-1:CODE_W], rand_code()};
      end else begin
        k = {rand_level(), rand_code()};
      end
      keys.push_back(k);
    end
    keys.sort();
    for (int i = 0; i < n_load; i++) begin
      vals[i] = rand_value();
      send_item(ACT_LOAD, rand_id(), keys[i][KEY_W-1:CODE_W], keys[i][CODE_W-1:0], vals[i]);
    end
    repeat (extra_loads)
      send_item(ACT_LOAD, rand_id(), rand_level(), rand_code(), rand_value());
    for (int i = 0; i < n_load && i < n_probe; i++) begin
      pick = $urandom_range(0, 9);
      // row just before the entry: skipped, flushes earlier entries
      if (pick < 2 && keys[i] != '0) begin
        k = keys[i] - 1'b1;
        send_item(ACT_PROBE, rand_id(), k[KEY_W-1:CODE_W], k[CODE_W-1:0], rand_value());
      end
      if (pick < 7)
        send_item(ACT_PROBE, rand_id(), keys[i][KEY_W-1:CODE_W], keys[i][CODE_W-1:0],
                  ($urandom_range(0, 2) == 0) ? rand_value() : vals[i]);
    end
    // late load becomes pending after the walk
    if ($urandom_range(0, 3) == 0)
      send_item(ACT_LOAD, rand_id(), rand_level(), rand_code(), rand_value());
    if ($urandom_range(0, 9) < 7)
      send_item(ACT_FINISH, rand_id(), rand_level(), rand_code(), rand_value());
  endtask

  // --------------------------------------------------------------------------
  // main stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned mark;
    int unsigned n_load;
    items_if.valid <= 1'b0;
    items_if.data  <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // empty table: probe and finish resolve nothing
    send_item(ACT_PROBE, ID_MAX, LEVEL_MAX, CODE_MAX, VALUE_MAX);
    send_item(ACT_FINISH, '0, '0, '0, '0);
    // key and value extremes
    send_item(ACT_LOAD, '0, '0, '0, '0);
    send_item(ACT_LOAD, ID_MAX, '0, CODE_MAX, VALUE_MAX);
    send_item(ACT_LOAD, rand_id(), 31'd1234, 16'd7, 64'h0123_4567_89ab_cdef);
    send_item(ACT_LOAD, rand_id(), LEVEL_MAX, '0, 64'h8000_0000_0000_0001);
    send_item(ACT_LOAD, rand_id(), LEVEL_MAX, CODE_MAX, 64'hfedc_ba98_7654_3210);
    // exact match, equal value
    send_item(ACT_PROBE, ID_MAX, '0, '0, '0);
    // exact match, value differs
    send_item(ACT_PROBE, '0, '0, CODE_MAX, 64'h5555_aaaa_5555_aaaa);
    // row sorts before the entry under the cursor
    send_item(ACT_PROBE, rand_id(), 31'd5, '0, rand_value());
    // one entry passed over, then stop on a later entry
    send_item(ACT_PROBE, rand_id(), 31'd1234, 16'd8, rand_value());
    // pass one entry, match the last
    send_item(ACT_PROBE, 31'h2aaa_5555, LEVEL_MAX, CODE_MAX, 64'hfedc_ba98_7654_3210);
    // table exhausted
    send_item(ACT_PROBE, rand_id(), LEVEL_MAX, CODE_MAX, rand_value());
    // loads after probing, one of them out of order
    send_item(ACT_LOAD, rand_id(), 31'd3, 16'd3, rand_value());
    send_item(ACT_LOAD, rand_id(), 31'd2, 16'd9, rand_value());
    send_item(ACT_PROBE, rand_id(), '0, '0, rand_value());
    send_item(ACT_FINISH, rand_id(), rand_level(), rand_code(), rand_value());
    send_item(ACT_FINISH, rand_id(), rand_level(), rand_code(), rand_value());
    send_item(ACT_CLEAR, rand_id(), rand_level(), rand_code(), rand_value());
    send_item(ACT_LOAD, rand_id(), 31'd10, 16'd1, rand_value());
    send_item(ACT_LOAD, rand_id(), 31'd20, 16'd2, rand_value());
    send_item(ACT_FINISH, rand_id(), rand_level(), rand_code(), rand_value());
    send_item(ACT_CLEAR, rand_id(), rand_level(), rand_code(), rand_value());
    drain_results();

    // full table with loads beyond it, while results are held off
    hold_req = 1'b1;
    run_sequence(TABLE_DEPTH, 2, FULL_PROBES);
    drain_results();

    // random runs and noise
    mark = n_sent;
    while (n_sent - mark < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(action_t'($urandom_range(0, 3)), rand_id(), rand_level(), rand_code(),
                    rand_value());
      end else begin
        pick_size : begin
          int unsigned r;
          r = $urandom_range(0, 99);
          n_load = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 20);
        end
        run_sequence(n_load, 0, n_load);
      end
      if ($urandom_range(0, 5) == 0)
        drain_results();
    end
    no_idle = 1'b0;

    // wait out the remaining results, then let the block settle
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0)
      $display("** sorted_merge_annotator_top: PASSED **");
    else
      $display("** sorted_merge_annotator_top: FAILED **");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("** sorted_merge_annotator_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sma_pkg.sv
sv/sma_in_if.sv
sv/sma_out_if.sv
sv/sma_table.sv
sv/sorted_merge_annotator_top.sv
tb/tb_top.sv
